// File: rtl/fers_pkg.sv
// Shared types and constants for the frame statistics block.
`timescale 1ns / 1ps
package fers_pkg;
   localparam int SAMPLE_BITS = 16;
   localparam int SUM_W    = 28;
   localparam int MEAN_W   = 16;
   localparam int ENERGY_W = 43;
   localparam int POWER_W  = 31;
   localparam int NORM_W   = 22;
   localparam int RMS_W    = 16;
   localparam int COUNT_W  = 13;

   typedef struct packed {
      logic [SUM_W-1:0]    sum;
      logic [ENERGY_W-1:0] energy;
      logic [COUNT_W-1:0]  count;
      logic                overflow;
   } frame_type;

   typedef struct packed {
      logic [SUM_W-1:0]    sum;
      logic [MEAN_W-1:0]   mean;
      logic [ENERGY_W-1:0] energy;
      logic [POWER_W-1:0]  power;
      logic [NORM_W-1:0]   norm;
      logic [RMS_W-1:0]    rms;
      logic [COUNT_W-1:0]  count;
      logic                overflow;
   } result_type;
endpackage

// File: rtl/fers_accum.sv
// Front part: accumulate sum, energy and count per frame.
`timescale 1ns / 1ps
module fers_accum import fers_pkg::*; #(
   parameter int FRAME_MAX   = 4096,
   parameter int CNT_W       = 17
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [15:0] sample,
   input  logic        frame_end,
   output logic        out_valid,
   input  logic        out_ready,
   output frame_type   out_frame,
   output logic [CNT_W-1:0] out_count
);
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [ENERGY_W-1:0] energy_ff, energy_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                ovf_ff, ovf_in;
   logic                room;
   logic signed [SAMPLE_BITS-1:0] s;
   logic signed [2*SAMPLE_BITS-1:0] sq;
   logic accept;

   assign s        = sample[SAMPLE_BITS-1:0];
   assign sq       = s * s;
   assign room     = count_ff < CNT_W'(FRAME_MAX);
   assign in_ready = out_ready;
   assign accept   = in_valid && in_ready;

   always_comb begin
      sum_in    = sum_ff;
      energy_in = energy_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      if (room) begin
         sum_in    = sum_ff + SUM_W'(s);
         energy_in = energy_ff + ENERGY_W'($unsigned(sq));
         count_in  = count_ff + 1'b1;
      end else begin
         ovf_in = 1'b1;
      end
   end

   assign out_valid          = accept && frame_end;
   assign out_frame.sum      = sum_in;
   assign out_frame.energy   = energy_in;
   assign out_frame.count    = count_in[COUNT_W-1:0];
   assign out_frame.overflow = ovf_in;
   assign out_count          = count_in;

   always_ff @(posedge clock) begin
      if (reset || (accept && frame_end)) begin
         sum_ff    <= '0;
         energy_ff <= '0;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
      end else if (accept) begin
         sum_ff    <= sum_in;
         energy_ff <= energy_in;
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
      end
   end
endmodule

// File: rtl/fers_calc.sv
// Back part: iterative divides and square roots for one closed frame.
`timescale 1ns / 1ps
module fers_calc import fers_pkg::*; #(
   parameter int CNT_W = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  frame_type        in_frame,
   input  logic [CNT_W-1:0] in_count,
   output logic             out_valid,
   input  logic             out_ready,
   output result_type       out_result
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_SQRT = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;
   localparam int DW = 44;

   logic [1:0]          state_ff, state_in;
   logic [5:0]          step_ff, step_in;
   frame_type           frm_ff;
   logic [CNT_W-1:0]    n_ff;
   logic [DW-1:0]       eq_ff, eq_in, er_ff, er_in;
   logic [SUM_W-1:0]    sq_ff, sq_in, sr_ff, sr_in;
   logic                neg_ff;
   logic [DW-1:0]       ev_ff, ev_in, er2_ff, er2_in, eroot_ff, eroot_in;
   logic [DW-1:0]       pv_ff, pv_in, pr_ff, pr_in, proot_ff, proot_in;
   logic [DW-1:0]       etrial, ptrial;
   logic [DW-1:0]       eshift;
   logic [SUM_W-1:0]    sshift;
   logic [SUM_W-1:0]    sabs;
   logic [SUM_W-1:0]    mean_full;

   assign in_ready  = state_ff == S_IDLE;
   assign out_valid = state_ff == S_OUT;
   assign sabs = in_frame.sum[SUM_W-1] ? SUM_W'(-in_frame.sum) : in_frame.sum;

   assign eshift = {er_ff[DW-2:0], eq_ff[DW-1]};
   assign sshift = {sr_ff[SUM_W-2:0], sq_ff[SUM_W-1]};
   assign etrial = {er2_ff[DW-3:0], ev_ff[DW-1:DW-2]};
   assign ptrial = {pr_ff[DW-3:0], pv_ff[DW-1:DW-2]};

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      eq_in = eq_ff; er_in = er_ff; sq_in = sq_ff; sr_in = sr_ff;
      ev_in = ev_ff; er2_in = er2_ff; eroot_in = eroot_ff;
      pv_in = pv_ff; pr_in = pr_ff; proot_in = proot_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               state_in = S_DIV;
               step_in  = '0;
               eq_in = DW'(in_frame.energy); er_in = '0;
               sq_in = sabs; sr_in = '0;
            end
         end
         S_DIV: begin
            eq_in = {eq_ff[DW-2:0], 1'b0};
            if (eshift >= DW'(n_ff)) begin
               er_in = eshift - DW'(n_ff); eq_in[0] = 1'b1;
            end else begin
               er_in = eshift;
            end
            if (step_ff < 6'(SUM_W)) begin
               sq_in = {sq_ff[SUM_W-2:0], 1'b0};
               if (DW'(sshift) >= DW'(n_ff)) begin
                  sr_in = SUM_W'(DW'(sshift) - DW'(n_ff)); sq_in[0] = 1'b1;
               end else begin
                  sr_in = sshift;
               end
            end
            step_in = step_ff + 1'b1;
            if (step_ff == 6'(DW-1)) begin
               state_in = S_SQRT;
               step_in  = '0;
               ev_in = DW'(frm_ff.energy); er2_in = '0; eroot_in = '0;
               pv_in = eq_in; pr_in = '0; proot_in = '0;
            end
         end
         S_SQRT: begin
            ev_in = {ev_ff[DW-3:0], 2'b00};
            pv_in = {pv_ff[DW-3:0], 2'b00};
            if (etrial >= {eroot_ff[DW-3:0], 2'b01}) begin
               er2_in = etrial - {eroot_ff[DW-3:0], 2'b01};
               eroot_in = {eroot_ff[DW-2:0], 1'b1};
            end else begin
               er2_in = etrial;
               eroot_in = {eroot_ff[DW-2:0], 1'b0};
            end
            if (ptrial >= {proot_ff[DW-3:0], 2'b01}) begin
               pr_in = ptrial - {proot_ff[DW-3:0], 2'b01};
               proot_in = {proot_ff[DW-2:0], 1'b1};
            end else begin
               pr_in = ptrial;
               proot_in = {proot_ff[DW-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == 6'(DW/2-1)) state_in = S_OUT;
         end
         S_OUT: begin
            if (out_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign mean_full = neg_ff ? SUM_W'(-sq_ff) : sq_ff;

   assign out_result.sum      = frm_ff.sum;
   assign out_result.mean     = mean_full[MEAN_W-1:0];
   assign out_result.energy   = frm_ff.energy;
   assign out_result.power    = eq_ff[POWER_W-1:0];
   assign out_result.norm     = eroot_ff[NORM_W-1:0];
   assign out_result.rms      = proot_ff[RMS_W-1:0];
   assign out_result.count    = frm_ff.count;
   assign out_result.overflow = frm_ff.overflow;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
      if (state_ff == S_IDLE && in_valid) begin
         frm_ff <= in_frame;
         n_ff   <= in_count;
         neg_ff <= in_frame.sum[SUM_W-1];
      end
      eq_ff <= eq_in; er_ff <= er_in; sq_ff <= sq_in; sr_ff <= sr_in;
      ev_ff <= ev_in; er2_ff <= er2_in; eroot_ff <= eroot_in;
      pv_ff <= pv_in; pr_ff <= pr_in; proot_ff <= proot_in;
   end
endmodule

// File: rtl/fers_queue.sv
// Two-entry queue of closed frames between front and back.
`timescale 1ns / 1ps
module fers_queue import fers_pkg::*; #(
   parameter int CNT_W = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  frame_type        in_frame,
   input  logic [CNT_W-1:0] in_count,
   output logic             out_valid,
   input  logic             out_ready,
   output frame_type        out_frame,
   output logic [CNT_W-1:0] out_count
);
   frame_type        frm_ff [2];
   logic [CNT_W-1:0] cnt_ff [2];
   logic             wp_ff, rp_ff;
   logic [1:0]       fill_ff;
   logic             push, pop;

   assign in_ready  = fill_ff != 2'd2;
   assign out_valid = fill_ff != 2'd0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_frame = frm_ff[rp_ff];
   assign out_count = cnt_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; fill_ff <= '0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         fill_ff <= fill_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) begin
         frm_ff[wp_ff] <= in_frame;
         cnt_ff[wp_ff] <= in_count;
      end
   end
endmodule

// File: rtl/frame_energy_rms_stats.sv
// Top level of the frame statistics block: sum, mean, energy, power, norm, RMS.
//  channel | direction | handshake             | payload
//  req     | in        | req_valid/req_ready   | req_sample, req_frame_end
//  rsp     | out       | rsp_valid/rsp_ready   | rsp_frame_* , rsp_sample_count, rsp_overflow
// Samples are taken one per cycle while the frame queue has room.
// Each closed frame holds the back unit while it is loaded, divided by restoring
// division, passed through bit-pair square roots and handed off.
// Reset clears accumulators, the queue and the back unit.
// A stalled rsp side fills the two-entry queue, then stalls req.
`timescale 1ns / 1ps
module frame_energy_rms_stats import fers_pkg::*; #(
   parameter int FRAME_MAX   = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_sample,
   input  logic        req_frame_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [27:0] rsp_frame_sum,
   output logic [15:0] rsp_frame_mean,
   output logic [42:0] rsp_frame_energy,
   output logic [30:0] rsp_frame_power,
   output logic [21:0] rsp_frame_norm,
   output logic [15:0] rsp_frame_rms,
   output logic [12:0] rsp_sample_count,
   output logic        rsp_overflow
);
   localparam int CNT_W = $clog2(FRAME_MAX + 1) + 1;

   logic             a_valid, a_ready, q_valid, q_ready;
   frame_type        a_frame, q_frame;
   logic [CNT_W-1:0] a_count, q_count;
   result_type       res;

   fers_accum #(.FRAME_MAX(FRAME_MAX), .CNT_W(CNT_W)) u_accum (
      .clock, .reset, .in_valid(req_valid), .in_ready(req_ready),
      .sample(req_sample), .frame_end(req_frame_end),
      .out_valid(a_valid), .out_ready(a_ready), .out_frame(a_frame), .out_count(a_count)
   );

   fers_queue #(.CNT_W(CNT_W)) u_queue (
      .clock, .reset, .in_valid(a_valid), .in_ready(a_ready),
      .in_frame(a_frame), .in_count(a_count),
      .out_valid(q_valid), .out_ready(q_ready), .out_frame(q_frame), .out_count(q_count)
   );

   fers_calc #(.CNT_W(CNT_W)) u_calc (
      .clock, .reset, .in_valid(q_valid), .in_ready(q_ready),
      .in_frame(q_frame), .in_count(q_count),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_result(res)
   );

   assign rsp_frame_sum    = res.sum;
   assign rsp_frame_mean   = res.mean;
   assign rsp_frame_energy = res.energy;
   assign rsp_frame_power  = res.power;
   assign rsp_frame_norm   = res.norm;
   assign rsp_frame_rms    = res.rms;
   assign rsp_sample_count = res.count;
   assign rsp_overflow     = res.overflow;

   a_front_stall: assert property (@(posedge clock) disable iff (reset)
      !a_ready |-> !req_ready) else $error("front took an item while queue full");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_power))
      else $error("result changed while stalled");
   a_rms_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_rms <= rsp_frame_norm[15:0] || rsp_frame_norm > 22'd65535)
      else $error("rms exceeds norm");
endmodule
